// ----- hdl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for the concurrent checks of the edge sweep tracker.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, ignored while reset is high.
`define ESTU_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("estu assertion failed");

// Check a property on every rising edge, reset cycles included.
`define ESTU_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("estu assertion failed");

`endif

// ----- hdl/estu_pkg.sv -----
// ---------------------------------------------------------------------------
// estu_pkg
// Widths, codes, types and helpers shared by the edge sweep tracker.
// ---------------------------------------------------------------------------
`default_nettype none

package estu_pkg;

   localparam int BUCKET_COUNT   = 8;
   localparam int NEEDED_BUCKETS = 6;

   localparam int RAW_W     = 12;
   localparam int POS_W     = 10;
   localparam int SPAN_W    = 10;
   localparam int EDGE_W    = 2;
   localparam int EXT_W     = 14;
   localparam int OUT_EXT_W = 14;
   localparam int COVER_W   = 7;
   localparam int COUNT_W   = 16;

   // bucket index width and product width of position times bucket count
   localparam int BKT_W  = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
   localparam int PROD_W = POS_W + $clog2(BUCKET_COUNT + 1);
   localparam int STEP_W = $clog2(BKT_W + 1);

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 12;
   localparam int REQ_DATA_W  = 24;
   localparam int RSP_DATA_W  = 72;

   localparam logic [EDGE_W-1:0] EDGE_RESET    = 2'd0;
   localparam logic [EDGE_W-1:0] EDGE_MIN_A    = 2'd0;
   localparam logic [EDGE_W-1:0] EDGE_MIN_B    = 2'd2;
   localparam logic [SPAN_W-1:0] SPAN_RESET    = 10'd800;
   localparam logic [RAW_W-1:0]  LIMIT_RESET   = 12'd0;

   localparam logic signed [EXT_W-1:0] SENT_HIGH = 14'sd4096;
   localparam logic signed [EXT_W-1:0] SENT_LOW  = -14'sd1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_EDGE_SELECT    = 2'd0,
      CSR_EDGE_SPAN      = 2'd1,
      CSR_HARDWARE_LIMIT = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      FRONT_IDLE,
      FRONT_DIVIDE,
      FRONT_PUSH
   } front_state_type;

   // classified request handed from front to back
   typedef struct packed {
      logic             restart;
      logic [RAW_W-1:0] raw;
      logic [BKT_W-1:0] bucket;
   } op_type;

   // result word, first member in the highest bits
   typedef struct packed {
      logic [2:0]           pad;
      logic [OUT_EXT_W-1:0] extreme_or_limit;
      logic                 limit_reached;
      logic                 sweep_done;
      logic [COUNT_W-1:0]   pinned_count;
      logic [COUNT_W-1:0]   sample_count;
      logic [COVER_W-1:0]   covered_count;
      logic [OUT_EXT_W-1:0] extreme_value;
   } rsp_type;

   function automatic logic track_min(input logic [EDGE_W-1:0] edge_sel);
      return (edge_sel == EDGE_MIN_A) || (edge_sel == EDGE_MIN_B);
   endfunction

endpackage

`default_nettype wire

// ----- hdl/estu_front.sv -----
// ---------------------------------------------------------------------------
// estu_front
// Accepts requests and works out the bucket index with a restoring divider.
// ---------------------------------------------------------------------------
`default_nettype none

module estu_front import estu_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic [SPAN_W-1:0] span,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_restart,
   input  logic [RAW_W-1:0]  req_raw,
   input  logic [POS_W-1:0]  req_pos,
   output logic              op_valid,
   input  logic              op_ready,
   output op_type            op
);

   front_state_type   state_ff, state_in;
   logic              restart_ff, restart_in;
   logic [RAW_W-1:0]  raw_ff, raw_in;
   logic [BKT_W-1:0]  bucket_ff, bucket_in;
   logic [SPAN_W-1:0] rem_ff, rem_in;
   logic [BKT_W-1:0]  low_ff, low_in;
   logic [STEP_W-1:0] step_ff, step_in;

   logic [SPAN_W-1:0] span_eff;
   logic [PROD_W-1:0] prod;
   logic              skip_div;
   logic [SPAN_W:0]   trial;
   logic              fits;

   assign span_eff = (span == '0) ? SPAN_W'(1) : span;
   assign prod     = PROD_W'(req_pos) * PROD_W'(BUCKET_COUNT);
   // position at or past the span lands in the last bucket
   assign skip_div = req_restart || (req_pos >= span_eff);
   assign trial    = {rem_ff, low_ff[BKT_W-1]};
   assign fits     = trial >= {1'b0, span_eff};

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FRONT_IDLE: begin
            if (req_valid) begin
               state_in = skip_div ? FRONT_PUSH : FRONT_DIVIDE;
            end
         end
         FRONT_DIVIDE: begin
            if (step_ff == STEP_W'(BKT_W - 1)) begin
               state_in = FRONT_PUSH;
            end
         end
         FRONT_PUSH: begin
            if (op_ready) begin
               state_in = FRONT_IDLE;
            end
         end
         default: state_in = FRONT_IDLE;
      endcase
   end

   always_comb begin
      req_ready = (state_ff == FRONT_IDLE);
      op_valid  = (state_ff == FRONT_PUSH);
   end

   always_comb begin
      restart_in = restart_ff;
      raw_in     = raw_ff;
      bucket_in  = bucket_ff;
      rem_in     = rem_ff;
      low_in     = low_ff;
      step_in    = step_ff;
      if (state_ff == FRONT_IDLE) begin
         restart_in = req_restart;
         raw_in     = req_raw;
         rem_in     = SPAN_W'(prod >> BKT_W);
         low_in     = prod[BKT_W-1:0];
         bucket_in  = skip_div ? BKT_W'(BUCKET_COUNT - 1) : '0;
         step_in    = '0;
      end else if (state_ff == FRONT_DIVIDE) begin
         rem_in    = fits ? SPAN_W'(trial - {1'b0, span_eff}) : SPAN_W'(trial);
         bucket_in = (bucket_ff << 1) | BKT_W'(fits);
         low_in    = low_ff << 1;
         step_in   = step_ff + STEP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FRONT_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      restart_ff <= restart_in;
      raw_ff     <= raw_in;
      bucket_ff  <= bucket_in;
      rem_ff     <= rem_in;
      low_ff     <= low_in;
      step_ff    <= step_in;
   end

   assign op.restart = restart_ff;
   assign op.raw     = raw_ff;
   assign op.bucket  = bucket_ff;

endmodule

`default_nettype wire

// ----- hdl/estu_queue.sv -----
// ---------------------------------------------------------------------------
// estu_queue
// Short first-in first-out queue between the front and the back.
// ---------------------------------------------------------------------------
`default_nettype none

module estu_queue import estu_pkg::*; (
   input  logic   clock,
   input  logic   reset,
   input  logic   in_valid,
   output logic   in_ready,
   input  op_type in_data,
   output logic   out_valid,
   input  logic   out_ready,
   output op_type out_data
);

   op_type            mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              push, pop;

   assign in_ready  = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_data  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/estu_back.sv -----
// ---------------------------------------------------------------------------
// estu_back
// Applies queued requests to the sweep state and registers the result.
// ---------------------------------------------------------------------------
`default_nettype none

module estu_back import estu_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic [EDGE_W-1:0] edge_sel,
   input  logic [RAW_W-1:0]  limit,
   input  logic              op_valid,
   output logic              op_ready,
   input  op_type            op,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_data
);

   logic signed [EXT_W-1:0]   ext_ff, ext_in;
   logic [BUCKET_COUNT-1:0]   hit_ff, hit_in;
   logic [COVER_W-1:0]        covered_ff, covered_in;
   logic [COUNT_W-1:0]        samples_ff, samples_in;
   logic [COUNT_W-1:0]        pinned_ff, pinned_in;
   logic                      done_ff, done_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_data_ff, rsp_data_in;

   logic                      pop;
   logic                      seek_low;
   logic signed [EXT_W-1:0]   raw_s;
   logic signed [EXT_W-1:0]   lim_s;
   logic                      beats;
   logic                      pinned;
   logic                      reached;

   assign op_ready = !rsp_valid_ff || rsp_ready;
   assign pop      = op_valid && op_ready;
   assign seek_low = track_min(edge_sel);
   assign raw_s    = signed'({{(EXT_W-RAW_W){1'b0}}, op.raw});
   assign lim_s    = signed'({{(EXT_W-RAW_W){1'b0}}, limit});
   assign beats    = seek_low ? (raw_s < ext_ff) : (raw_s > ext_ff);
   assign pinned   = seek_low ? (raw_s <= lim_s) : (raw_s >= lim_s);

   always_comb begin
      ext_in     = ext_ff;
      hit_in     = hit_ff;
      covered_in = covered_ff;
      samples_in = samples_ff;
      pinned_in  = pinned_ff;
      done_in    = done_ff;
      if (pop) begin
         if (op.restart) begin
            ext_in     = seek_low ? SENT_HIGH : SENT_LOW;
            hit_in     = '0;
            covered_in = '0;
            samples_in = '0;
            pinned_in  = '0;
            done_in    = 1'b0;
         end else begin
            if (beats) begin
               ext_in = raw_s;
            end
            if (!hit_ff[op.bucket]) begin
               hit_in[op.bucket] = 1'b1;
               covered_in        = covered_ff + COVER_W'(1);
            end
            if (samples_ff != '1) begin
               samples_in = samples_ff + COUNT_W'(1);
            end
            if (pinned && (pinned_ff != '1)) begin
               pinned_in = pinned_ff + COUNT_W'(1);
            end
            done_in = done_ff || (covered_in >= COVER_W'(NEEDED_BUCKETS));
         end
      end
   end

   assign reached = (covered_in != '0) &&
                    (seek_low ? (ext_in <= lim_s) : (ext_in >= lim_s));

   always_comb begin
      rsp_data_in                  = rsp_data_ff;
      rsp_valid_in                 = rsp_valid_ff;
      if (pop) begin
         rsp_valid_in                  = 1'b1;
         rsp_data_in.pad               = '0;
         rsp_data_in.extreme_value     = ext_in;
         rsp_data_in.covered_count     = covered_in;
         rsp_data_in.sample_count      = samples_in;
         rsp_data_in.pinned_count      = pinned_in;
         rsp_data_in.sweep_done        = done_in;
         rsp_data_in.limit_reached     = reached;
         rsp_data_in.extreme_or_limit  = done_in ? ext_in : {2'b00, limit};
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ext_ff       <= SENT_HIGH;
         hit_ff       <= '0;
         covered_ff   <= '0;
         samples_ff   <= '0;
         pinned_ff    <= '0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ext_ff       <= ext_in;
         hit_ff       <= hit_in;
         covered_ff   <= covered_in;
         samples_ff   <= samples_in;
         pinned_ff    <= pinned_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ----- hdl/edge_sweep_extreme_tracker_unit.sv -----
// ---------------------------------------------------------------------------
// edge_sweep_extreme_tracker_unit
// Touch-panel edge sweep tracker: running extreme, coverage and counters.
// ---------------------------------------------------------------------------
// Each request either restarts the sweep or adds one sample, and every
// request returns exactly one response holding the state after the update.
// A sample is placed in bucket position * BUCKET_COUNT / span (span zero
// counts as one), clamped to the last bucket. The bucket index comes from a
// restoring divider in the front part that resolves one quotient bit per
// cycle, three bits for eight buckets, so a sample passes through accept,
// three divide steps and hand-off, while a restart or a position at or
// beyond the span skips the divide steps. The back part updates the sweep
// state and holds the response in an output register; a two-entry queue
// between the parts lets the front take the next request while the back
// waits for the response to be taken. Edge select 0 and 2 track the
// minimum raw value, 1 and 3 the maximum. Restart loads the extreme with a
// sentinel (4096 for minimum, -1 for maximum); reset loads 4096. Sample and
// pinned counters saturate at 65535. Write configuration only while no
// request is in flight.
// ---------------------------------------------------------------------------
`default_nettype none

module edge_sweep_extreme_tracker_unit import estu_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   // configuration write port
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   // request stream
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,   // raw_reading[11:0], along_position[21:12]
   input  logic [0:0]             req_tuser,   // command[0]: 1 restarts the sweep
   // response stream
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata    // extreme_value[13:0], covered_count[20:14],
                                               // sample_count[36:21], pinned_count[52:37],
                                               // sweep_done[53], limit_reached[54],
                                               // extreme_or_limit[68:55]
);

   // configuration registers
   logic [EDGE_W-1:0] edge_sel_ff, edge_sel_in;
   logic [SPAN_W-1:0] span_ff, span_in;
   logic [RAW_W-1:0]  limit_ff, limit_in;

   // front to queue, queue to back
   logic    fq_valid, fq_ready;
   op_type  fq_op;
   logic    qb_valid, qb_ready;
   op_type  qb_op;
   rsp_type rsp_word;

   // decode configuration writes; an unused index is dropped
   always_comb begin
      edge_sel_in = edge_sel_ff;
      span_in     = span_ff;
      limit_in    = limit_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_EDGE_SELECT:    edge_sel_in = csr_wdata[EDGE_W-1:0];
            CSR_EDGE_SPAN:      span_in     = csr_wdata[SPAN_W-1:0];
            CSR_HARDWARE_LIMIT: limit_in    = csr_wdata[RAW_W-1:0];
            default:            ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         edge_sel_ff <= EDGE_RESET;
         span_ff     <= SPAN_RESET;
         limit_ff    <= LIMIT_RESET;
      end else begin
         edge_sel_ff <= edge_sel_in;
         span_ff     <= span_in;
         limit_ff    <= limit_in;
      end
   end

   // accept requests and classify them into a bucket
   estu_front u_front (
      .clock       (clock),
      .reset       (reset),
      .span        (span_ff),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_restart (req_tuser[0]),
      .req_raw     (req_tdata[RAW_W-1:0]),
      .req_pos     (req_tdata[RAW_W+POS_W-1:RAW_W]),
      .op_valid    (fq_valid),
      .op_ready    (fq_ready),
      .op          (fq_op)
   );

   // decouple the divider from the response stall
   estu_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_valid),
      .in_ready  (fq_ready),
      .in_data   (fq_op),
      .out_valid (qb_valid),
      .out_ready (qb_ready),
      .out_data  (qb_op)
   );

   // update the sweep state and hold the response
   estu_back u_back (
      .clock     (clock),
      .reset     (reset),
      .edge_sel  (edge_sel_ff),
      .limit     (limit_ff),
      .op_valid  (qb_valid),
      .op_ready  (qb_ready),
      .op        (qb_op),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_data  (rsp_word)
   );

   assign rsp_tdata = rsp_word;

endmodule

`default_nettype wire

// ----- hdl/estu_checker.sv -----
// ---------------------------------------------------------------------------
// estu_checker
// Port-level checks of the edge sweep tracker, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module estu_checker import estu_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   rsp_type rsp_view;

   assign rsp_view = rsp_type'(rsp_tdata);

   // no response survives reset
   `ESTU_ASSERT_ALWAYS(a_rsp_clear_after_reset, clock, reset |=> !rsp_tvalid)

   // a stalled response holds
   `ESTU_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))

   // done only with enough covered buckets
   `ESTU_ASSERT(a_done_covered, clock, reset, rsp_tvalid && rsp_view.sweep_done |-> rsp_view.covered_count >= COVER_W'(NEEDED_BUCKETS))

   // once done, the answer is the extreme
   `ESTU_ASSERT(a_done_answer, clock, reset, rsp_tvalid && rsp_view.sweep_done |-> rsp_view.extreme_or_limit == rsp_view.extreme_value)

   // pinned samples are a subset of all samples
   `ESTU_ASSERT(a_pinned_le_samples, clock, reset, rsp_tvalid |-> rsp_view.pinned_count <= rsp_view.sample_count)

endmodule

bind edge_sweep_extreme_tracker_unit estu_checker u_estu_checker (.*);

`default_nettype wire
